// File: hdl/kvbrp_pkg.sv
// ----------------------------------------------------------------------------
// kvbrp_pkg
// Shared types and constants of the key/value block record parser.
// ----------------------------------------------------------------------------
`default_nettype none

package kvbrp_pkg;

    localparam int DEF_MAGIC_LENGTH = 8;
    localparam int MAX_RESULTS      = 3;
    localparam int Q_DEPTH          = 4;
    localparam int CFG_AW           = 3;

    localparam logic [CFG_AW-1:2] REG_LENGTH_BIG_ENDIAN = 1'b0;

    localparam logic [7:0] MAGIC_BYTES [16] = '{
        8'h44, 8'h41, 8'h54, 8'h41, 8'h42, 8'h4C, 8'h4B, 8'h22,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
    };

    typedef enum logic [2:0] {
        PH_MAGIC,
        PH_KLEN,
        PH_VLEN,
        PH_KEY,
        PH_VAL,
        PH_SKIP
    } t_phase;

    typedef enum logic [1:0] {
        KIND_KEY,
        KIND_VALUE,
        KIND_RECORD,
        KIND_BLOCK
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK,
        ST_BAD_MAGIC,
        ST_TRUNCATED
    } t_status;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] payload;
        logic [1:0] block_status;
        logic       result_last;
    } t_result;

    typedef struct packed {
        logic [1:0]                   n;
        t_result [MAX_RESULTS-1:0]    res;
    } t_push;

endpackage

`default_nettype wire

// File: hdl/kvbrp_if.sv
// ----------------------------------------------------------------------------
// kvbrp_if
// Byte input channel and result output channel of the record parser.
// ----------------------------------------------------------------------------
`default_nettype none

interface kvbrp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface kvbrp_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [7:0] payload;
    logic [1:0] block_status;
    logic       result_last;

    modport source (output valid, output kind, output payload, output block_status,
                    output result_last, input ready);
    modport sink   (input valid, input kind, input payload, input block_status,
                    input result_last, output ready);
endinterface

`default_nettype wire

// File: hdl/kv_block_record_parser_top.sv
// ----------------------------------------------------------------------------
// kv_block_record_parser_top
// Length-prefixed key/value record parser for one uncompressed block.
// ----------------------------------------------------------------------------
// Bytes of a block arrive one per beat with a final-byte flag. The block must
// open with the magic, then records follow: 32-bit key length, 32-bit value
// length (byte order from the length_big_endian register at address 0), key
// bytes and value bytes. Each key or value byte comes out as one result, a
// record-complete marker follows each record, and the final byte yields a
// block-finished result with its status. A byte is taken every cycle while at
// most one result per byte is produced and the result channel is not stalled;
// its results are written to the result queue. A byte causing two or three
// results uses the four-entry result queue, which drains one result per cycle
// while the channel is ready; input is held until it is down to one entry.
// ----------------------------------------------------------------------------
`default_nettype none

module kv_block_record_parser_top #(
    parameter int MAGIC_LENGTH = kvbrp_pkg::DEF_MAGIC_LENGTH
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    kvbrp_in_if.sink                          i_byte,
    kvbrp_out_if.source                       o_result,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [kvbrp_pkg::CFG_AW-1:0] paddr,
    input  wire logic [31:0]                  pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready
);
    import kvbrp_pkg::*;

    logic  s_big_endian;
    logic  s_room;
    t_push s_push;

    kvbrp_cfg u_cfg (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .o_big_endian (s_big_endian)
    );

    kvbrp_parser #(
        .MAGIC_LENGTH (MAGIC_LENGTH)
    ) u_parser (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .in_ch        (i_byte),
        .i_room       (s_room),
        .i_big_endian (s_big_endian),
        .o_push       (s_push)
    );

    kvbrp_result_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (s_push),
        .o_room  (s_room),
        .out_ch  (o_result)
    );

endmodule

`default_nettype wire

// File: hdl/kvbrp_cfg.sv
// ----------------------------------------------------------------------------
// kvbrp_cfg
// APB-style register port holding the length byte order.
// ----------------------------------------------------------------------------
`default_nettype none

module kvbrp_cfg (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [kvbrp_pkg::CFG_AW-1:0] paddr,
    input  wire logic [31:0]                  pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready,
    output logic                              o_big_endian
);
    import kvbrp_pkg::*;

    logic r_big_endian;
    logic s_sel;

    assign s_sel  = (paddr[CFG_AW-1:2] == REG_LENGTH_BIG_ENDIAN);
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_big_endian <= 1'b1;
        end else if (psel && penable && pwrite && s_sel) begin
            r_big_endian <= pwdata[0];
        end
    end

    assign prdata       = s_sel ? {31'd0, r_big_endian} : 32'd0;
    assign o_big_endian = r_big_endian;

endmodule

`default_nettype wire

// File: hdl/kvbrp_parser.sv
// ----------------------------------------------------------------------------
// kvbrp_parser
// Per-byte parse state and result generation, one byte per beat.
// ----------------------------------------------------------------------------
`default_nettype none

module kvbrp_parser #(
    parameter int MAGIC_LENGTH = kvbrp_pkg::DEF_MAGIC_LENGTH
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    kvbrp_in_if.sink        in_ch,
    input  wire logic       i_room,
    input  wire logic       i_big_endian,
    output kvbrp_pkg::t_push o_push
);
    import kvbrp_pkg::*;

    t_phase      r_phase, n_phase;
    logic [1:0]  r_idx, n_idx;
    logic [31:0] r_klen, n_klen;
    logic [31:0] r_vlen, n_vlen;
    logic [31:0] r_rem, n_rem;

    logic        s_fire;
    logic        s_emit_byte;
    t_kind       s_byte_kind;
    logic        s_emit_rec;
    t_status     s_status;

    function automatic logic [31:0] gather(input logic [31:0] cur, input logic [7:0] b,
                                           input logic [1:0] idx, input logic big);
        logic [31:0] base;
        logic [31:0] res;
        base = (idx == 2'd0) ? 32'd0 : cur;
        res  = base;
        if (big) begin
            res = {base[23:0], b};
        end else begin
            case (idx)
                2'd0:    res[7:0]   = b;
                2'd1:    res[15:8]  = b;
                2'd2:    res[23:16] = b;
                default: res[31:24] = b;
            endcase
        end
        return res;
    endfunction

    assign in_ch.ready = i_room;
    assign s_fire      = in_ch.valid && i_room;

    always_comb begin
        n_phase     = r_phase;
        n_idx       = r_idx;
        n_klen      = r_klen;
        n_vlen      = r_vlen;
        n_rem       = r_rem;
        s_emit_byte = 1'b0;
        s_byte_kind = KIND_KEY;
        s_emit_rec  = 1'b0;
        unique case (r_phase)
            PH_MAGIC: begin
                if (in_ch.data_byte != MAGIC_BYTES[r_rem[3:0]]) begin
                    n_phase = PH_SKIP;
                end else if (r_rem + 32'd1 == 32'(MAGIC_LENGTH)) begin
                    n_phase = PH_KLEN;
                    n_idx   = 2'd0;
                    n_rem   = 32'd0;
                end else begin
                    n_rem = r_rem + 32'd1;
                end
            end
            PH_KLEN: begin
                n_klen = gather(r_klen, in_ch.data_byte, r_idx, i_big_endian);
                n_idx  = r_idx + 2'd1;
                if (r_idx == 2'd3) begin
                    n_phase = PH_VLEN;
                end
            end
            PH_VLEN: begin
                n_vlen = gather(r_vlen, in_ch.data_byte, r_idx, i_big_endian);
                n_idx  = r_idx + 2'd1;
                if (r_idx == 2'd3) begin
                    if (r_klen != 32'd0) begin
                        n_phase = PH_KEY;
                        n_rem   = r_klen;
                    end else if (n_vlen != 32'd0) begin
                        n_phase = PH_VAL;
                        n_rem   = n_vlen;
                    end else begin
                        s_emit_rec = 1'b1;
                        n_phase    = PH_KLEN;
                        n_rem      = 32'd0;
                    end
                end
            end
            PH_KEY: begin
                s_emit_byte = 1'b1;
                s_byte_kind = KIND_KEY;
                n_rem       = r_rem - 32'd1;
                if (r_rem == 32'd1) begin
                    if (r_vlen != 32'd0) begin
                        n_phase = PH_VAL;
                        n_rem   = r_vlen;
                    end else begin
                        s_emit_rec = 1'b1;
                        n_phase    = PH_KLEN;
                        n_idx      = 2'd0;
                    end
                end
            end
            PH_VAL: begin
                s_emit_byte = 1'b1;
                s_byte_kind = KIND_VALUE;
                n_rem       = r_rem - 32'd1;
                if (r_rem == 32'd1) begin
                    s_emit_rec = 1'b1;
                    n_phase    = PH_KLEN;
                    n_idx      = 2'd0;
                end
            end
            default: begin
            end
        endcase

        if (n_phase == PH_MAGIC || n_phase == PH_SKIP) begin
            s_status = ST_BAD_MAGIC;
        end else if (n_phase == PH_KLEN && n_idx == 2'd0) begin
            s_status = ST_OK;
        end else begin
            s_status = ST_TRUNCATED;
        end

        if (in_ch.last_byte) begin
            n_phase = PH_MAGIC;
            n_idx   = 2'd0;
            n_klen  = 32'd0;
            n_vlen  = 32'd0;
            n_rem   = 32'd0;
        end
    end

    always_comb begin
        logic [1:0] k;
        o_push = '0;
        k      = 2'd0;
        if (s_emit_byte) begin
            o_push.res[k].kind    = s_byte_kind;
            o_push.res[k].payload = in_ch.data_byte;
            k = k + 2'd1;
        end
        if (s_emit_rec) begin
            o_push.res[k].kind = KIND_RECORD;
            k = k + 2'd1;
        end
        if (in_ch.last_byte) begin
            o_push.res[k].kind         = KIND_BLOCK;
            o_push.res[k].block_status = s_status;
            k = k + 2'd1;
        end
        if (k != 2'd0) begin
            o_push.res[k - 2'd1].result_last = 1'b1;
        end
        o_push.n = s_fire ? k : 2'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_MAGIC;
            r_idx   <= 2'd0;
            r_klen  <= 32'd0;
            r_vlen  <= 32'd0;
            r_rem   <= 32'd0;
        end else if (s_fire) begin
            r_phase <= n_phase;
            r_idx   <= n_idx;
            r_klen  <= n_klen;
            r_vlen  <= n_vlen;
            r_rem   <= n_rem;
        end
    end

    a_last_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_fire && in_ch.last_byte |=> r_phase == PH_MAGIC && r_rem == 32'd0)
        else $error("parser did not restart after final byte");

    a_payload_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_KEY || r_phase == PH_VAL) |-> r_rem != 32'd0)
        else $error("payload phase with nothing left to take");

    a_group_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push.n != 2'd0 |-> o_push.res[o_push.n - 2'd1].result_last)
        else $error("result group lacks its final mark");

endmodule

`default_nettype wire

// File: hdl/kvbrp_result_queue.sv
// ----------------------------------------------------------------------------
// kvbrp_result_queue
// Small result queue: takes up to three results a beat, delivers one.
// ----------------------------------------------------------------------------
`default_nettype none

module kvbrp_result_queue (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire kvbrp_pkg::t_push i_push,
    output logic                 o_room,
    kvbrp_out_if.source          out_ch
);
    import kvbrp_pkg::*;

    localparam int QAW = $clog2(Q_DEPTH);
    localparam int CW  = $clog2(Q_DEPTH + 1);

    t_result          r_buf [Q_DEPTH];
    logic [QAW-1:0]   r_head, n_head;
    logic [CW-1:0]    r_count, n_count;
    logic [QAW-1:0]   s_tail;
    logic             s_pop;
    t_result          s_out;

    assign s_tail = r_head + r_count[QAW-1:0];
    assign s_pop  = out_ch.valid && out_ch.ready;
    assign o_room = (r_count <= CW'(Q_DEPTH - MAX_RESULTS));

    assign n_head  = s_pop ? r_head + QAW'(1) : r_head;
    assign n_count = r_count + CW'(i_push.n) - CW'(s_pop);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_count <= '0;
        end else begin
            r_head  <= n_head;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < MAX_RESULTS; k++) begin
            if (2'(k) < i_push.n) begin
                r_buf[s_tail + QAW'(k)] <= i_push.res[k];
            end
        end
    end

    assign s_out               = r_buf[r_head];
    assign out_ch.valid        = (r_count != '0);
    assign out_ch.kind         = s_out.kind;
    assign out_ch.payload      = s_out.payload;
    assign out_ch.block_status = s_out.block_status;
    assign out_ch.result_last  = s_out.result_last;

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push.n != 2'd0 |-> r_count + CW'(i_push.n) <= CW'(Q_DEPTH))
        else $error("result queue overflow");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(Q_DEPTH))
        else $error("result queue count out of range");

    a_head_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_ch.valid && !out_ch.ready |=> $stable(r_head))
        else $error("result queue head moved without a beat");

endmodule

`default_nettype wire
